// File: rtl/asmtok_pkg.sv
// ----------------------------------------------------------------------------
// asmtok_pkg
// Shared types and constants of the assembly source tokenizer.
// ----------------------------------------------------------------------------
package asmtok_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] ChZero    = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChOne     = 8'h31;  // '1'
  localparam logic [CharW-1:0] ChB       = 8'h62;  // 'b'
  localparam logic [CharW-1:0] ChX       = 8'h78;  // 'x'
  localparam logic [CharW-1:0] ChPercent = 8'h25;  // '%'
  localparam logic [CharW-1:0] ChComma   = 8'h2c;  // ','
  localparam logic [CharW-1:0] ChNewline = 8'h0a;  // '\n'

  typedef enum logic [KindW-1:0] {
    KIND_IDENT = 4'd0,
    KIND_BIN   = 4'd1,
    KIND_HEX   = 4'd2,
    KIND_DEC   = 4'd3,
    KIND_PCT   = 4'd4,
    KIND_COMMA = 4'd5,
    KIND_EOL   = 4'd6,
    KIND_UNK   = 4'd7,
    KIND_EOF   = 4'd8
  } kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_IDENT = 6'b000010,
    MODE_ZERO  = 6'b000100,
    MODE_BIN   = 6'b001000,
    MODE_HEX   = 6'b010000,
    MODE_DEC   = 6'b100000
  } mode_e;

  // One token item: kind, text character, character flag, last-item mark.
  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] ch;
    logic             has;
    logic             last;
  } tok_t;

endpackage

// File: rtl/assembly_source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_top
// Streaming lexer for a small assembly language, one source byte per beat.
// ----------------------------------------------------------------------------
// Feed one ASCII byte per input beat; a beat with tlast set marks end of input
// and closes the open token with an end-of-file item. Each input beat is
// classified against the scan mode in the same cycle it is accepted and yields
// zero, one or two token items, which land in a four-entry result queue. The
// output drains one item per cycle while the sink is ready, and input runs at
// one byte per cycle only while the queue has room for a beat's items; tready drops
// while the queue has fewer than two free entries. Identifier and number tokens
// come out one character per item, then a last item without one when the run
// closes; a lone 0 is a single last item holding '0'. cfg_data_i sets whether
// a newline gives an end-of-line token (1, the reset value) or is skipped.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_data_i,      // emit_end_of_line
  // Source byte stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_char
  input  logic       s_axis_tlast_i,  // end_of_input
  // Token item stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] text_char
  output logic [4:0] m_axis_tuser_o,  // [3:0] token_kind, [4] has_char
  output logic       m_axis_tlast_o   // token_end
);

  asmtok_pkg::mode_e mode_q, mode_d, mode_nxt;
  logic              emit_eol_q;
  logic              in_beat;
  logic [1:0]        num, push_num;
  asmtok_pkg::tok_t  tok0, tok1, head;
  logic              room;

  // Configuration is always taken; it is to be written only while idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  assign s_axis_tready_o = room;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  asmtok_classify u_classify (
    .mode_i     (mode_q),
    .char_i     (s_axis_tdata_i),
    .eoi_i      (s_axis_tlast_i),
    .emit_eol_i (emit_eol_q),
    .mode_o     (mode_nxt),
    .tok0_o     (tok0),
    .tok1_o     (tok1),
    .num_o      (num)
  );

  // Advance the scan mode and push items only on an accepted beat.
  assign mode_d   = in_beat ? mode_nxt : mode_q;
  assign push_num = in_beat ? num : 2'd0;

  asmtok_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .push0_i    (tok0),
    .push1_i    (tok1),
    .room_o     (room),
    .valid_o    (m_axis_tvalid_o),
    .pop_i      (m_axis_tready_i),
    .head_o     (head)
  );

  assign m_axis_tdata_o = head.ch;
  assign m_axis_tuser_o = {head.has, head.kind};
  assign m_axis_tlast_o = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= asmtok_pkg::MODE_IDLE;
      emit_eol_q <= 1'b1;
    end else begin
      mode_q <= mode_d;
      if (cfg_valid_i && cfg_ready_o) begin
        emit_eol_q <= cfg_data_i[0];
      end
    end
  end

endmodule

// File: rtl/asmtok_classify.sv
// ----------------------------------------------------------------------------
// asmtok_classify
// Character classification and scan-mode step: gives up to two token items
// and the next mode for one input beat.
// ----------------------------------------------------------------------------
module asmtok_classify (
  input  asmtok_pkg::mode_e                mode_i,
  input  logic [asmtok_pkg::CharW-1:0]     char_i,
  input  logic                             eoi_i,
  input  logic                             emit_eol_i,
  output asmtok_pkg::mode_e                mode_o,
  output asmtok_pkg::tok_t                 tok0_o,
  output asmtok_pkg::tok_t                 tok1_o,
  output logic [1:0]                       num_o
);

  typedef struct packed {
    logic              v;
    asmtok_pkg::tok_t  tok;
    asmtok_pkg::mode_e mode;
  } start_t;

  function automatic logic is_alpha(logic [asmtok_pkg::CharW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [asmtok_pkg::CharW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_xdigit(logic [asmtok_pkg::CharW-1:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_space(logic [asmtok_pkg::CharW-1:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic asmtok_pkg::tok_t mk(asmtok_pkg::kind_e k,
                                          logic [asmtok_pkg::CharW-1:0] c,
                                          logic has, logic last);
    asmtok_pkg::tok_t t;
    t.kind = k;
    t.ch   = has ? c : '0;
    t.has  = has;
    t.last = last;
    return t;
  endfunction

  // Open a token from an idle scanner.
  function automatic start_t start(logic [asmtok_pkg::CharW-1:0] c, logic eol);
    start_t s;
    s.v    = 1'b1;
    s.mode = asmtok_pkg::MODE_IDLE;
    s.tok  = mk(asmtok_pkg::KIND_UNK, c, 1'b1, 1'b1);
    if (c == asmtok_pkg::ChNewline && eol) begin
      s.tok = mk(asmtok_pkg::KIND_EOL, c, 1'b1, 1'b1);
    end else if (is_space(c)) begin
      s.v = 1'b0;
    end else if (is_alpha(c)) begin
      s.mode = asmtok_pkg::MODE_IDENT;
      s.tok  = mk(asmtok_pkg::KIND_IDENT, c, 1'b1, 1'b0);
    end else if (c == asmtok_pkg::ChZero) begin
      s.v    = 1'b0;
      s.mode = asmtok_pkg::MODE_ZERO;
    end else if (is_digit(c)) begin
      s.mode = asmtok_pkg::MODE_DEC;
      s.tok  = mk(asmtok_pkg::KIND_DEC, c, 1'b1, 1'b0);
    end else if (c == asmtok_pkg::ChPercent) begin
      s.tok = mk(asmtok_pkg::KIND_PCT, c, 1'b1, 1'b1);
    end else if (c == asmtok_pkg::ChComma) begin
      s.tok = mk(asmtok_pkg::KIND_COMMA, c, 1'b1, 1'b1);
    end
    return s;
  endfunction

  asmtok_pkg::tok_t  eof_tok;
  asmtok_pkg::tok_t  close_tok;
  asmtok_pkg::kind_e run_kind;
  logic              keep;
  logic              in_run;
  start_t            st;

  assign eof_tok   = mk(asmtok_pkg::KIND_EOF, '0, 1'b0, 1'b1);
  assign close_tok = mk(run_kind, '0, 1'b0, 1'b1);
  assign st        = start(char_i, emit_eol_i);

  always_comb begin
    run_kind = asmtok_pkg::KIND_IDENT;
    keep     = 1'b0;
    in_run   = 1'b1;
    unique case (mode_i)
      asmtok_pkg::MODE_IDENT: begin
        run_kind = asmtok_pkg::KIND_IDENT;
        keep     = is_alpha(char_i) || is_digit(char_i);
      end
      asmtok_pkg::MODE_BIN: begin
        run_kind = asmtok_pkg::KIND_BIN;
        keep     = char_i == asmtok_pkg::ChZero || char_i == asmtok_pkg::ChOne;
      end
      asmtok_pkg::MODE_HEX: begin
        run_kind = asmtok_pkg::KIND_HEX;
        keep     = is_xdigit(char_i);
      end
      asmtok_pkg::MODE_DEC: begin
        run_kind = asmtok_pkg::KIND_DEC;
        keep     = is_digit(char_i);
      end
      default: in_run = 1'b0;
    endcase
  end

  always_comb begin
    mode_o = asmtok_pkg::MODE_IDLE;
    tok0_o = eof_tok;
    tok1_o = eof_tok;
    num_o  = 2'd0;
    if (in_run) begin
      if (eoi_i) begin
        tok0_o = close_tok;
        num_o  = 2'd2;
      end else if (keep) begin
        mode_o = mode_i;
        tok0_o = mk(run_kind, char_i, 1'b1, 1'b0);
        num_o  = 2'd1;
      end else begin
        tok0_o = close_tok;
        tok1_o = st.tok;
        mode_o = st.mode;
        num_o  = st.v ? 2'd2 : 2'd1;
      end
    end else if (mode_i == asmtok_pkg::MODE_ZERO) begin
      tok0_o = mk(asmtok_pkg::KIND_DEC, asmtok_pkg::ChZero, 1'b1, 1'b1);
      if (eoi_i) begin
        num_o = 2'd2;
      end else if (char_i == asmtok_pkg::ChB) begin
        mode_o = asmtok_pkg::MODE_BIN;
      end else if (char_i == asmtok_pkg::ChX) begin
        mode_o = asmtok_pkg::MODE_HEX;
      end else if (is_digit(char_i)) begin
        mode_o = asmtok_pkg::MODE_DEC;
        tok0_o = mk(asmtok_pkg::KIND_DEC, asmtok_pkg::ChZero, 1'b1, 1'b0);
        tok1_o = mk(asmtok_pkg::KIND_DEC, char_i, 1'b1, 1'b0);
        num_o  = 2'd2;
      end else begin
        tok1_o = st.tok;
        mode_o = st.mode;
        num_o  = st.v ? 2'd2 : 2'd1;
      end
    end else begin
      if (eoi_i) begin
        num_o = 2'd1;
      end else begin
        tok0_o = st.tok;
        mode_o = st.mode;
        num_o  = st.v ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

// File: rtl/asmtok_outq.sv
// ----------------------------------------------------------------------------
// asmtok_outq
// Small result queue: takes up to two items per cycle, drains one when popped.
// ----------------------------------------------------------------------------
module asmtok_outq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     push_num_i,
  input  asmtok_pkg::tok_t               push0_i,
  input  asmtok_pkg::tok_t               push1_i,
  output logic                           room_o,
  output logic                           valid_o,
  input  logic                           pop_i,
  output asmtok_pkg::tok_t               head_o
);

  asmtok_pkg::tok_t mem_q [asmtok_pkg::QDepth];

  logic [asmtok_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [asmtok_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                         pop;

  // room_o is high only while at least two entries are free for a beat.
  assign room_o  = cnt_q <= asmtok_pkg::QCntW'(asmtok_pkg::QDepth - 2);
  assign valid_o = cnt_q != '0;
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];
  assign wr_nxt  = wr_q + asmtok_pkg::QPtrW'(1);

  always_comb begin
    wr_d  = wr_q + asmtok_pkg::QPtrW'(push_num_i);
    rd_d  = pop ? rd_q + asmtok_pkg::QPtrW'(1) : rd_q;
    cnt_d = cnt_q + asmtok_pkg::QCntW'(push_num_i) - asmtok_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
